// File: sv/ffba_pkg.sv
// Shared types and constants for the first-fit bitmap allocator.
// No dependencies; every other file refers to this package by scoped names.
package ffba_pkg;

	localparam int POOL_BYTES_DEF = 512;
	localparam int SIZE_W         = 10;
	localparam int OFS_W          = 9;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NOSPACE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_SCAN,
		ST_MARK,
		ST_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic in_rdy;
		logic clr;
		logic free_init;
		logic scan;
		logic mark;
		logic out_ld;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic in_vld;
		logic clr_last;
		logic is_free;
		logic free_in;
		logic bad_size;
		logic hit;
		logic scan_last;
		logic mark_done;
		logic out_full;
	} sts_t;

endpackage

// File: sv/ffba_if.sv
// Request and response channel interfaces (valid/ready) of the allocator.
// Depends on ffba_pkg for field widths.
interface ffba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [ffba_pkg::SIZE_W-1:0] req_size;
	logic [ffba_pkg::OFS_W-1:0]  free_offset;

	modport source (output valid, cmd, req_size, free_offset, input ready);
	modport sink   (input valid, cmd, req_size, free_offset, output ready);
endinterface

interface ffba_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [ffba_pkg::OFS_W-1:0] start_offset;

	modport source (output valid, status, start_offset, input ready);
	modport sink   (input valid, status, start_offset, output ready);
endinterface

// File: sv/ffba_ctrl.sv
// Sequencer of the allocator: clear pass, decode, scan, mark, respond.
// Depends on ffba_pkg; drives the datapath through ctl_t, reads sts_t.
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::ctl_t  ctl
);

	ffba_pkg::state_t state_q;
	ffba_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		unique case (state_q)
			ffba_pkg::ST_CLEAR: begin
				ctl.clr = 1'b1;
				if (sts.clr_last) state_nx = ffba_pkg::ST_IDLE;
			end
			ffba_pkg::ST_IDLE: begin
				ctl.in_rdy = 1'b1;
				if (sts.in_vld) state_nx = ffba_pkg::ST_DISP;
			end
			ffba_pkg::ST_DISP: begin
				if (sts.is_free) begin
					if (sts.free_in) begin
						ctl.free_init = 1'b1;
						state_nx      = ffba_pkg::ST_MARK;
					end else begin
						state_nx = ffba_pkg::ST_RESP;
					end
				end else if (sts.bad_size) begin
					state_nx = ffba_pkg::ST_RESP;
				end else begin
					state_nx = ffba_pkg::ST_SCAN;
				end
			end
			ffba_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.hit) state_nx = ffba_pkg::ST_MARK;
				else if (sts.scan_last) state_nx = ffba_pkg::ST_RESP;
			end
			ffba_pkg::ST_MARK: begin
				if (sts.mark_done) state_nx = ffba_pkg::ST_RESP;
				else ctl.mark = 1'b1;
			end
			ffba_pkg::ST_RESP: begin
				// wait only while the previous result is still unclaimed
				if (!sts.out_full) begin
					ctl.out_ld = 1'b1;
					state_nx   = ffba_pkg::ST_IDLE;
				end
			end
			default: state_nx = ffba_pkg::ST_CLEAR;
		endcase
	end

	a_accept_to_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_IDLE && sts.in_vld) |=> (state_q == ffba_pkg::ST_DISP))
		else $error("accepted beat did not advance to decode");

	a_hit_to_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_SCAN && sts.hit) |=> (state_q == ffba_pkg::ST_MARK))
		else $error("found run was not marked");

endmodule

// File: sv/ffba_datapath.sv
// Datapath: used-bit memory, scan pointer and run counter, mark counter,
// request capture and response register. Depends on ffba_pkg and ffba_if.
module ffba_datapath #(
	parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ffba_req_if.sink        req,
	ffba_rsp_if.source      rsp,
	input  ffba_pkg::ctl_t  ctl,
	output ffba_pkg::sts_t  sts
);

	localparam int PW = $clog2(POOL_BYTES + 1);
	localparam int AW = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
	localparam int CW = (PW > ffba_pkg::SIZE_W) ? PW : ffba_pkg::SIZE_W;
	localparam logic [PW-1:0] POOL_P = PW'(POOL_BYTES);
	localparam logic [PW-1:0] LAST_P = PW'(POOL_BYTES - 1);
	localparam logic [CW-1:0] POOL_C = CW'(POOL_BYTES);

	logic mem_q [POOL_BYTES];

	logic [PW-1:0]                ptr_q;
	logic                         chk_v_s1;
	logic [PW-1:0]                chk_addr_s1;
	logic                         rd_data_s1;
	logic [CW-1:0]                run_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                start_q;
	logic                         fail_q;
	logic                         cmd_q;
	logic [ffba_pkg::SIZE_W-1:0]  size_q;
	logic [ffba_pkg::OFS_W-1:0]   ofs_q;
	logic                         out_valid_q;
	logic                         out_status_q;
	logic [ffba_pkg::OFS_W-1:0]   out_start_q;

	logic          accept;
	logic          rd_en;
	logic          wr_en;
	logic          wr_data;
	logic          hit;
	logic [CW-1:0] size_c;
	logic [CW-1:0] ofs_c;
	logic [CW-1:0] run_nx;
	logic [CW-1:0] start_c;
	logic [CW-1:0] room;
	logic [CW-1:0] free_len;

	assign accept  = ctl.in_rdy && req.valid;
	assign size_c  = CW'(size_q);
	assign ofs_c   = CW'(ofs_q);
	assign run_nx  = run_q + CW'(1);
	assign start_c = CW'(chk_addr_s1) + CW'(1) - size_c;
	assign room    = POOL_C - ofs_c;
	assign free_len = (size_c < room) ? size_c : room;

	assign rd_en   = ctl.scan && (ptr_q < POOL_P);
	assign wr_en   = ctl.clr || ctl.mark;
	assign wr_data = ctl.mark && (cmd_q == ffba_pkg::CMD_ALLOC);
	assign hit     = ctl.scan && chk_v_s1 && !rd_data_s1 && (run_nx == size_c);

	assign req.ready = ctl.in_rdy;

	always_comb begin
		sts           = '0;
		sts.in_vld    = req.valid;
		sts.clr_last  = (ptr_q == LAST_P);
		sts.is_free   = (cmd_q == ffba_pkg::CMD_FREE);
		sts.free_in   = (ofs_c < POOL_C);
		sts.bad_size  = (size_q == '0) || (size_c > POOL_C);
		sts.hit       = hit;
		sts.scan_last = ctl.scan && chk_v_s1 && (chk_addr_s1 == LAST_P);
		sts.mark_done = (cnt_q == '0);
		sts.out_full  = out_valid_q && !rsp.ready;
	end

	// single-port bit memory: written during clear/mark, read during scan
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[ptr_q[AW-1:0]] <= wr_data;
		if (rd_en) rd_data_s1 <= mem_q[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			chk_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_v_s1 <= rd_en;
			if (accept) ptr_q <= '0;
			else if (hit) ptr_q <= start_c[PW-1:0];
			else if (ctl.free_init) ptr_q <= ofs_c[PW-1:0];
			else if (wr_en || rd_en) ptr_q <= ptr_q + PW'(1);
			if (ctl.out_ld) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_s1 <= ptr_q;
		if (accept) begin
			cmd_q   <= req.cmd;
			size_q  <= req.req_size;
			ofs_q   <= req.free_offset;
			run_q   <= '0;
			start_q <= '0;
			fail_q  <= (req.cmd == ffba_pkg::CMD_ALLOC);
		end else if (ctl.scan && chk_v_s1) begin
			run_q <= rd_data_s1 ? '0 : run_nx;
			if (hit) begin
				start_q <= start_c;
				fail_q  <= 1'b0;
			end
		end
		if (hit) cnt_q <= size_c;
		else if (ctl.free_init) cnt_q <= free_len;
		else if (ctl.mark) cnt_q <= cnt_q - CW'(1);
		if (ctl.out_ld) begin
			out_status_q <= fail_q ? ffba_pkg::STATUS_NOSPACE : ffba_pkg::STATUS_OK;
			out_start_q  <= start_q[ffba_pkg::OFS_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.start_offset = out_start_q;

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("bit memory read and written in one cycle");

	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mark |-> (cnt_q != '0))
		else $error("mark write past end of run");

	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_ld && fail_q) |=> (rsp.start_offset == '0))
		else $error("failed allocate returned nonzero offset");

endmodule

// File: sv/first_fit_bitmap_allocator.sv
// First-fit bitmap allocator, one request at a time.
// An allocate is decoded, scanned for the first free run of its size, marked and
//   answered; a free clears its length; zero-size or oversize allocates skip the scan.
// One used bit is read per scan cycle and one bit written per mark cycle, through
//   the single memory port.
// Reset: asynchronous; a clear pass zeroes the map first.
module first_fit_bitmap_allocator #(
	parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);

	ffba_pkg::ctl_t ctl;
	ffba_pkg::sts_t sts;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	ffba_datapath #(
		.POOL_BYTES (POOL_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

// File: sim/first_fit_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_bitmap_allocator: predicts every reply
// from a bitmap copy kept at request acceptance. Needs ffba_pkg and ffba_if.
module first_fit_bitmap_allocator_tb;

	localparam int POOL         = ffba_pkg::POOL_BYTES_DEF;
	localparam int RANDOM_ITEMS = 580;
	localparam int HOLD_CYCLES  = 4000;
	localparam int DRAIN_CYCLES = 2 * POOL + 64;
	localparam int CYCLE_LIMIT  = 4_000_000;

	typedef struct {
		logic                       status;
		logic [ffba_pkg::OFS_W-1:0] start_offset;
	} reply_t;

	// Bitmap copy plus the replies still owed by the block, oldest first.
	class pool_map_model;
		bit     used[POOL];
		reply_t replies_due[$];
		int     live_ofs[$];
		int     live_len[$];
		int     errors;

		task report(string msg);
			errors++;
			$display("ERROR @%0t: %s", $time, msg);
		endtask

		function void note_request(logic cmd, int size, int ofs);
			reply_t r;
			int     run;
			int     s;
			int     p;
			int     i;
			r.status       = ffba_pkg::STATUS_OK;
			r.start_offset = '0;
			if (cmd == ffba_pkg::CMD_ALLOC) begin
				r.status = ffba_pkg::STATUS_NOSPACE;
				if (size != 0 && size <= POOL) begin
					run = 0;
					for (p = 0; p < POOL; p++) begin
						run = used[p] ? 0 : run + 1;
						if (run == size) begin
							s = p + 1 - size;
							for (i = s; i <= p; i++)
								used[i] = 1'b1;
							r.status       = ffba_pkg::STATUS_OK;
							r.start_offset = s[ffba_pkg::OFS_W-1:0];
							live_ofs.push_back(s);
							live_len.push_back(size);
							break;
						end
					end
				end
			end else if (ofs < POOL) begin
				for (i = ofs; i < ofs + size && i < POOL; i++)
					used[i] = 1'b0;
			end
			replies_due.push_back(r);
		endfunction

		task check_reply(logic status, logic [ffba_pkg::OFS_W-1:0] ofs);
			reply_t e;
			if (replies_due.size() == 0) begin
				report($sformatf("reply with none due: status=%0b offset=%0d", status, ofs));
				return;
			end
			e = replies_due.pop_front();
			if (status !== e.status)
				report($sformatf("status %0b, expected %0b", status, e.status));
			if (ofs !== e.start_offset)
				report($sformatf("start_offset %0d, expected %0d", ofs, e.start_offset));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_req;
	int   cycle_count = 0;

	pool_map_model pool_map = new();

	ffba_req_if req_ch();
	ffba_rsp_if rsp_ch();

	first_fit_bitmap_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Valid is left high after a beat; it only drops when an idle gap is taken.
	task automatic send_req(logic cmd, int size, int ofs);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.req_size    <= size[ffba_pkg::SIZE_W-1:0];
		req_ch.free_offset <= ofs[ffba_pkg::OFS_W-1:0];
		do @(posedge clk); while (!req_ch.ready);
		pool_map.note_request(cmd, size, ofs);
	endtask

	task automatic send_random_req();
		int pick;
		int size;
		int idx;
		pick = $urandom_range(99);
		if (pick < 55) begin
			pick = $urandom_range(99);
			if (pick < 80)
				size = $urandom_range(24, 1);
			else if (pick < 92)
				size = $urandom_range(160, 25);
			else if (pick < 97)
				size = $urandom_range(POOL, 161);
			else if (pick < 98)
				size = 0;
			else
				size = $urandom_range(1023, POOL + 1);
			send_req(ffba_pkg::CMD_ALLOC, size, $urandom_range(POOL - 1));
		end else if (pick < 90 && pool_map.live_ofs.size() > 0) begin
			// well-formed free of a run handed out earlier
			idx = $urandom_range(pool_map.live_ofs.size() - 1);
			send_req(ffba_pkg::CMD_FREE, pool_map.live_len[idx], pool_map.live_ofs[idx]);
			pool_map.live_ofs.delete(idx);
			pool_map.live_len.delete(idx);
		end else begin
			size = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(64);
			send_req(ffba_pkg::CMD_FREE, size, $urandom_range(POOL - 1));
		end
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				pool_map.check_reply(rsp_ch.status, rsp_ch.start_offset);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int n;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= ffba_pkg::CMD_ALLOC;
		req_ch.req_size    <= '0;
		req_ch.free_offset <= '0;
		arst_n        = 1'b0;
		hold_req      = 1'b0;
		send_idle_pct = 37;
		recv_idle_pct = 57;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: size extremes, pool edges, odd frees
		send_req(ffba_pkg::CMD_ALLOC, 0, 0);
		send_req(ffba_pkg::CMD_ALLOC, 1023, 511);
		send_req(ffba_pkg::CMD_ALLOC, POOL + 1, 0);
		send_req(ffba_pkg::CMD_ALLOC, POOL, 0);
		send_req(ffba_pkg::CMD_ALLOC, 1, 0);
		send_req(ffba_pkg::CMD_FREE, 1023, 0);
		send_req(ffba_pkg::CMD_ALLOC, 1, 0);
		send_req(ffba_pkg::CMD_ALLOC, 3, 0);
		send_req(ffba_pkg::CMD_FREE, 0, 1);
		send_req(ffba_pkg::CMD_FREE, 1, POOL - 1);
		send_req(ffba_pkg::CMD_ALLOC, POOL - 4, 0);
		send_req(ffba_pkg::CMD_FREE, 2, 0);
		send_req(ffba_pkg::CMD_ALLOC, 2, 0);
		send_req(ffba_pkg::CMD_ALLOC, 1, 0);
		send_req(ffba_pkg::CMD_FREE, 10, 256);
		send_req(ffba_pkg::CMD_FREE, 5, 300);
		send_req(ffba_pkg::CMD_ALLOC, 5, 0);
		send_req(ffba_pkg::CMD_ALLOC, 6, 0);
		send_req(ffba_pkg::CMD_ALLOC, 5, 0);
		send_req(ffba_pkg::CMD_FREE, 300, POOL - 2);
		send_req(ffba_pkg::CMD_ALLOC, 2, 0);
		send_req(ffba_pkg::CMD_FREE, 600, 0);
		pool_map.live_ofs.delete();
		pool_map.live_len.delete();

		for (n = 0; n < RANDOM_ITEMS / 3; n++)
			send_random_req();
		send_idle_pct = 57;
		recv_idle_pct = 37;
		for (n = 0; n < RANDOM_ITEMS / 3; n++)
			send_random_req();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 1'b1;
		for (n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++)
			send_random_req();
		req_ch.valid <= 1'b0;

		while (pool_map.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pool_map.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
